### src/sfst_pkg.sv
// Shared types, score constants, mode codes and saturating add for the span score table.
`timescale 1ns / 1ps

package sfst_pkg;

   // Signed Q16.16 score; the most negative code stands for minus infinity
   typedef logic signed [31:0] score_type;

   localparam score_type NegInf = score_type'(32'h8000_0000);
   localparam score_type PosMax = score_type'(32'h7FFF_FFFF);

   // Request mode codes
   typedef logic [1:0] mode_type;
   localparam mode_type MODE_CLEAR = 2'd0;
   localparam mode_type MODE_LOAD  = 2'd1;
   localparam mode_type MODE_RUN   = 2'd2;
   localparam mode_type MODE_READ  = 2'd3;

   // Response kinds
   localparam logic RESULT_READ = 1'b0;
   localparam logic RESULT_RUN  = 1'b1;

   // Word counts up to 511 inclusive
   typedef logic [8:0] count_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_LOAD_RD,
      ST_LOAD_WR,
      ST_READ_RD,
      ST_READ_OUT,
      ST_RUN_SPAN,
      ST_RUN_SCAN,
      ST_RUN_DRAIN,
      ST_RUN_WRITE,
      ST_RUN_DONE
   } state_type;

   // Tags issued with each memory read during a run
   typedef struct packed {
      logic take_base;
      logic take_pair;
   } cmb_ctl_type;

   // Add two scores; minus infinity absorbs, the rest saturates
   function automatic score_type sat_add(score_type a, score_type b);
      logic [32:0] sum;
      score_type   res;
      sum = {a[31], a} + {b[31], b};
      if (a == NegInf || b == NegInf) begin
         res = NegInf;
      end else if (sum[32] != sum[31]) begin
         res = sum[32] ? NegInf : PosMax;
      end else begin
         res = score_type'(sum[31:0]);
      end
      return res;
   endfunction

endpackage

### src/sfst_req_if.sv
// Request channel: mode, span and option score with valid/ready.
`timescale 1ns / 1ps

interface sfst_req_if;
   logic                valid;
   logic                ready;
   logic [1:0]          mode;
   logic [5:0]          span_start;
   logic [5:0]          span_end;
   sfst_pkg::score_type option_score;

   modport source (output valid, mode, span_start, span_end, option_score, input ready);
   modport sink   (input valid, mode, span_start, span_end, option_score, output ready);
endinterface

### src/sfst_rsp_if.sv
// Response channel: read answers and run completion with valid/ready.
`timescale 1ns / 1ps

interface sfst_rsp_if;
   logic                valid;
   logic                ready;
   logic                result_kind;
   sfst_pkg::score_type span_score;
   logic                unreached;

   modport source (output valid, result_kind, span_score, unreached, input ready);
   modport sink   (input valid, result_kind, span_score, unreached, output ready);
endinterface

### src/sfst_csr_if.sv
// Configuration write channel carrying the sentence length.
`timescale 1ns / 1ps

interface sfst_csr_if;
   logic       valid;
   logic       ready;
   logic [6:0] sentence_length;

   modport source (output valid, sentence_length, input ready);
   modport sink   (input valid, sentence_length, output ready);
endinterface

### src/sfst_table_mem.sv
// Score table memory: two registered read ports and one write port.
`timescale 1ns / 1ps

module sfst_table_mem #(
   parameter int AW = 12
) (
   input  logic                clock,
   input  logic [AW-1:0]       ra_a,
   input  logic [AW-1:0]       ra_b,
   output sfst_pkg::score_type rd_a,
   output sfst_pkg::score_type rd_b,
   input  logic                we,
   input  logic [AW-1:0]       wa,
   input  sfst_pkg::score_type wd
);

   sfst_pkg::score_type score_mem_ff [0:(1 << AW) - 1];
   sfst_pkg::score_type rd_a_ff;
   sfst_pkg::score_type rd_b_ff;

   // Write one cell, read two cells through registered outputs
   always_ff @(posedge clock) begin
      if (we) begin
         score_mem_ff[wa] <= wd;
      end
      rd_a_ff <= score_mem_ff[ra_a];
      rd_b_ff <= score_mem_ff[ra_b];
   end

   assign rd_a = rd_a_ff;
   assign rd_b = rd_b_ff;

endmodule

### src/sfst_combine.sv
// Run datapath: sums two sub-span scores and keeps the best for the current span.
`timescale 1ns / 1ps

module sfst_combine (
   input  logic                  clock,
   input  logic                  reset,
   input  sfst_pkg::cmb_ctl_type ctl,
   input  sfst_pkg::score_type   rd_a,
   input  sfst_pkg::score_type   rd_b,
   output sfst_pkg::score_type   best,
   output logic                  busy
);

   logic                base_d_ff;
   logic                pair_d_ff;
   logic                sum_vld_ff;
   sfst_pkg::score_type sum_ff;
   sfst_pkg::score_type sum_in;
   sfst_pkg::score_type best_ff;
   sfst_pkg::score_type best_in;

   // Follow read tags to the cycle in which the memory data arrives
   always_ff @(posedge clock) begin
      if (reset) begin
         base_d_ff  <= 1'b0;
         pair_d_ff  <= 1'b0;
         sum_vld_ff <= 1'b0;
      end else begin
         base_d_ff  <= ctl.take_base;
         pair_d_ff  <= ctl.take_pair;
         sum_vld_ff <= pair_d_ff;
      end
   end

   // Add the pair, then fold the sum into the running best; a base value replaces the best
   always_comb begin
      sum_in  = pair_d_ff ? sfst_pkg::sat_add(rd_a, rd_b) : sum_ff;
      best_in = best_ff;
      priority if (base_d_ff) begin
         best_in = rd_a;
      end else if (sum_vld_ff && (sum_ff > best_ff)) begin
         best_in = sum_ff;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff  <= sum_in;
      best_ff <= best_in;
   end

   assign best = best_ff;
   assign busy = base_d_ff | pair_d_ff | sum_vld_ff;

endmodule

### src/sfst_seq.sv
// Sequencer: dispatches requests, walks spans for a run and drives the response register.
`timescale 1ns / 1ps

module sfst_seq #(
   parameter int MAX_WORDS = 64,
   parameter int PW = $clog2(MAX_WORDS),
   parameter int AW = 2 * PW
) (
   input  logic                  clock,
   input  logic                  reset,
   sfst_req_if.sink              req_ch,
   sfst_rsp_if.source            rsp_ch,
   input  sfst_pkg::count_type   n_words,
   output logic [AW-1:0]         mem_ra_a,
   output logic [AW-1:0]         mem_ra_b,
   output logic                  mem_we,
   output logic [AW-1:0]         mem_wa,
   output sfst_pkg::score_type   mem_wd,
   input  sfst_pkg::score_type   mem_rd_a,
   output sfst_pkg::cmb_ctl_type cmb_ctl,
   input  sfst_pkg::score_type   cmb_best,
   input  logic                  cmb_busy
);

   localparam sfst_pkg::count_type MaxWordsC = sfst_pkg::count_type'(MAX_WORDS);

   sfst_pkg::state_type state_ff, state_in;
   logic [PW-1:0]       pos_s_ff, pos_s_in;
   logic [PW-1:0]       pos_e_ff, pos_e_in;
   logic                span_ok_ff, span_ok_in;
   sfst_pkg::score_type opt_ff, opt_in;
   logic [PW-1:0]       len_ff, len_in;
   logic [PW-1:0]       run_s_ff, run_s_in;
   logic [PW-1:0]       run_k_ff, run_k_in;
   logic [AW-1:0]       clr_ff, clr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_kind_ff, rsp_kind_in;
   sfst_pkg::score_type rsp_score_ff, rsp_score_in;
   logic                rsp_unreached_ff, rsp_unreached_in;

   logic                accept;
   logic                slot_free;
   logic                rsp_load;
   logic                req_ok;
   logic [PW-1:0]       run_e;
   logic [PW-1:0]       run_k1;
   sfst_pkg::score_type rd_score;

   assign req_ch.ready = (state_ff == sfst_pkg::ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign slot_free    = !rsp_valid_ff || rsp_ch.ready;
   assign run_e        = run_s_ff + len_ff;
   assign run_k1       = run_k_ff + PW'(1);
   assign rd_score     = span_ok_ff ? mem_rd_a : sfst_pkg::NegInf;

   // Check the span against the table size and its end against its start
   assign req_ok = (sfst_pkg::count_type'(req_ch.span_start) < MaxWordsC) &&
                   (sfst_pkg::count_type'(req_ch.span_end) < MaxWordsC) &&
                   (req_ch.span_end >= req_ch.span_start);

   // Next state, memory accesses and counters
   always_comb begin
      state_in         = state_ff;
      pos_s_in         = pos_s_ff;
      pos_e_in         = pos_e_ff;
      span_ok_in       = span_ok_ff;
      opt_in           = opt_ff;
      len_in           = len_ff;
      run_s_in         = run_s_ff;
      run_k_in         = run_k_ff;
      clr_in           = clr_ff;
      rsp_load         = 1'b0;
      rsp_kind_in      = rsp_kind_ff;
      rsp_score_in     = rsp_score_ff;
      rsp_unreached_in = rsp_unreached_ff;
      mem_ra_a         = {pos_s_ff, pos_e_ff};
      mem_ra_b         = {run_k1, run_e};
      mem_we           = 1'b0;
      mem_wa           = {pos_s_ff, pos_e_ff};
      mem_wd           = opt_ff;
      cmb_ctl          = '0;

      unique case (state_ff)
         sfst_pkg::ST_IDLE: begin
            if (accept) begin
               pos_s_in   = PW'(req_ch.span_start);
               pos_e_in   = PW'(req_ch.span_end);
               span_ok_in = req_ok;
               opt_in     = req_ch.option_score;
               unique case (req_ch.mode)
                  sfst_pkg::MODE_CLEAR: begin
                     clr_in   = '0;
                     state_in = sfst_pkg::ST_CLEAR;
                  end
                  sfst_pkg::MODE_LOAD: begin
                     state_in = sfst_pkg::ST_LOAD_RD;
                  end
                  sfst_pkg::MODE_RUN: begin
                     len_in   = PW'(1);
                     run_s_in = '0;
                     if (n_words <= sfst_pkg::count_type'(1)) begin
                        state_in = sfst_pkg::ST_RUN_DONE;
                     end else begin
                        state_in = sfst_pkg::ST_RUN_SPAN;
                     end
                  end
                  sfst_pkg::MODE_READ: begin
                     state_in = sfst_pkg::ST_READ_RD;
                  end
               endcase
            end
         end

         // Sweep every cell to minus infinity
         sfst_pkg::ST_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = sfst_pkg::NegInf;
            clr_in = clr_ff + AW'(1);
            if (&clr_ff) begin
               state_in = sfst_pkg::ST_IDLE;
            end
         end

         sfst_pkg::ST_LOAD_RD: begin
            state_in = sfst_pkg::ST_LOAD_WR;
         end

         // Keep the larger of cell and offered score for an in-range span
         sfst_pkg::ST_LOAD_WR: begin
            if (span_ok_ff && (opt_ff > mem_rd_a)) begin
               mem_we = 1'b1;
            end
            state_in = sfst_pkg::ST_IDLE;
         end

         sfst_pkg::ST_READ_RD: begin
            state_in = sfst_pkg::ST_READ_OUT;
         end

         // Hold the read address until the response slot frees
         sfst_pkg::ST_READ_OUT: begin
            if (slot_free) begin
               rsp_load         = 1'b1;
               rsp_kind_in      = sfst_pkg::RESULT_READ;
               rsp_score_in     = rd_score;
               rsp_unreached_in = (rd_score == sfst_pkg::NegInf);
               state_in         = sfst_pkg::ST_IDLE;
            end
         end

         // Fetch the span's own value as the starting best
         sfst_pkg::ST_RUN_SPAN: begin
            mem_ra_a          = {run_s_ff, run_e};
            cmb_ctl.take_base = 1'b1;
            run_k_in          = run_s_ff;
            state_in          = sfst_pkg::ST_RUN_SCAN;
         end

         // Fetch one split point per cycle
         sfst_pkg::ST_RUN_SCAN: begin
            mem_ra_a          = {run_s_ff, run_k_ff};
            mem_ra_b          = {run_k1, run_e};
            cmb_ctl.take_pair = 1'b1;
            if (run_k1 == run_e) begin
               state_in = sfst_pkg::ST_RUN_DRAIN;
            end else begin
               run_k_in = run_k1;
            end
         end

         sfst_pkg::ST_RUN_DRAIN: begin
            if (!cmb_busy) begin
               state_in = sfst_pkg::ST_RUN_WRITE;
            end
         end

         // Store the best, then advance start or length, or finish
         sfst_pkg::ST_RUN_WRITE: begin
            mem_we = 1'b1;
            mem_wa = {run_s_ff, run_e};
            mem_wd = cmb_best;
            if ((sfst_pkg::count_type'(run_e) + sfst_pkg::count_type'(1)) < n_words) begin
               run_s_in = run_s_ff + PW'(1);
               state_in = sfst_pkg::ST_RUN_SPAN;
            end else if ((sfst_pkg::count_type'(len_ff) + sfst_pkg::count_type'(1)) < n_words)
            begin
               len_in   = len_ff + PW'(1);
               run_s_in = '0;
               state_in = sfst_pkg::ST_RUN_SPAN;
            end else begin
               state_in = sfst_pkg::ST_RUN_DONE;
            end
         end

         sfst_pkg::ST_RUN_DONE: begin
            if (slot_free) begin
               rsp_load         = 1'b1;
               rsp_kind_in      = sfst_pkg::RESULT_RUN;
               rsp_score_in     = '0;
               rsp_unreached_in = 1'b0;
               state_in         = sfst_pkg::ST_IDLE;
            end
         end
      endcase
   end

   // Response slot: fill on load, drop on transfer
   always_comb begin
      priority if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sfst_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_s_ff         <= pos_s_in;
      pos_e_ff         <= pos_e_in;
      span_ok_ff       <= span_ok_in;
      opt_ff           <= opt_in;
      len_ff           <= len_in;
      run_s_ff         <= run_s_in;
      run_k_ff         <= run_k_in;
      clr_ff           <= clr_in;
      rsp_kind_ff      <= rsp_kind_in;
      rsp_score_ff     <= rsp_score_in;
      rsp_unreached_ff <= rsp_unreached_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.result_kind = rsp_kind_ff;
   assign rsp_ch.span_score  = rsp_score_ff;
   assign rsp_ch.unreached   = rsp_unreached_ff;

`ifndef ASSERT_OFF
   // The best must be settled before it is written back
   a_write_settled: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sfst_pkg::ST_RUN_WRITE) |-> !cmb_busy)
      else $error("span written while combine pipeline busy");

   // Split points stay inside the span
   a_split_inside: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sfst_pkg::ST_RUN_SCAN) |-> (run_k_ff < run_e))
      else $error("split point outside span");

   // A run span never reaches past the sentence
   a_span_in_sentence: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sfst_pkg::ST_RUN_SPAN) |-> (sfst_pkg::count_type'(run_e) < n_words))
      else $error("run span beyond sentence length");

   // Every accepted request leaves idle in the following cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != sfst_pkg::ST_IDLE))
      else $error("request accepted without leaving idle");
`endif

endmodule

### src/span_future_score_table.sv
// Top level of the span score table: configuration register, sequencer, datapath and memory.
`timescale 1ns / 1ps

// Span score table. One cell per word span [start, end] holds a signed Q16.16 score, the
// most negative code meaning minus infinity; cells live in one synchronous memory with
// two read ports of 2^(2*ceil(log2 MAX_WORDS)) entries. Requests are handled one at a
// time and the request channel is ready only while the sequencer is idle. A clear sweeps
// the whole memory, one cell per cycle. A load accepts, reads the memory cell and then
// writes back. A read passes a memory read to reach the response register and waits
// before it while the previous response is still untaken. A run visits every span of two
// or more words of the sentence by rising length, fetching one split point per cycle
// through the memory's two read ports. The table content is undefined after reset until
// the first clear. sentence_length resets to 1.

module span_future_score_table #(
   parameter int MAX_WORDS = 64
) (
   input  logic       clock,
   input  logic       reset,
   sfst_req_if.sink   req_ch,
   sfst_rsp_if.source rsp_ch,
   sfst_csr_if.sink   csr_ch
);

   localparam int PW = $clog2(MAX_WORDS);
   localparam int AW = 2 * PW;
   localparam sfst_pkg::count_type MaxWordsC = sfst_pkg::count_type'(MAX_WORDS);

   logic [6:0]            sentence_length_ff, sentence_length_in;
   sfst_pkg::count_type   n_words;
   sfst_pkg::count_type   len_c;

   logic [AW-1:0]         mem_ra_a;
   logic [AW-1:0]         mem_ra_b;
   logic                  mem_we;
   logic [AW-1:0]         mem_wa;
   sfst_pkg::score_type   mem_wd;
   sfst_pkg::score_type   mem_rd_a;
   sfst_pkg::score_type   mem_rd_b;
   sfst_pkg::cmb_ctl_type cmb_ctl;
   sfst_pkg::score_type   cmb_best;
   logic                  cmb_busy;

   // Sentence length register, written on each configuration transfer
   assign csr_ch.ready       = 1'b1;
   assign sentence_length_in = (csr_ch.valid && csr_ch.ready) ? csr_ch.sentence_length
                                                              : sentence_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sentence_length_ff <= 7'd1;
      end else begin
         sentence_length_ff <= sentence_length_in;
      end
   end

   // Clamp the sentence to the table size
   assign len_c   = sfst_pkg::count_type'(sentence_length_ff);
   assign n_words = (len_c > MaxWordsC) ? MaxWordsC : len_c;

   sfst_seq #(
      .MAX_WORDS (MAX_WORDS),
      .PW        (PW),
      .AW        (AW)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .rsp_ch   (rsp_ch),
      .n_words  (n_words),
      .mem_ra_a (mem_ra_a),
      .mem_ra_b (mem_ra_b),
      .mem_we   (mem_we),
      .mem_wa   (mem_wa),
      .mem_wd   (mem_wd),
      .mem_rd_a (mem_rd_a),
      .cmb_ctl  (cmb_ctl),
      .cmb_best (cmb_best),
      .cmb_busy (cmb_busy)
   );

   sfst_combine u_combine (
      .clock (clock),
      .reset (reset),
      .ctl   (cmb_ctl),
      .rd_a  (mem_rd_a),
      .rd_b  (mem_rd_b),
      .best  (cmb_best),
      .busy  (cmb_busy)
   );

   sfst_table_mem #(
      .AW (AW)
   ) u_table_mem (
      .clock (clock),
      .ra_a  (mem_ra_a),
      .ra_b  (mem_ra_b),
      .rd_a  (mem_rd_a),
      .rd_b  (mem_rd_b),
      .we    (mem_we),
      .wa    (mem_wa),
      .wd    (mem_wd)
   );

endmodule
